@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the deque core.
// Sampled on aclk, disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge out of reset.
`define BDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that a condition implies another one in the next cycle.
`define BDQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/core/bdq_pkg.sv @@
// Shared types and constants for the bounded deque core.
// No dependencies.
package bdq_pkg;

    localparam int CAPACITY = 64;
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 7;

    // slot position and fill count widths
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // read select tree: groups of up to eight slots
    localparam int GROUP_W = (IDX_W < 3) ? IDX_W : 3;
    localparam int GROUP   = 1 << GROUP_W;
    localparam int NGROUP  = (CAPACITY + GROUP - 1) / GROUP;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_REMOVE     = 3'd4,
        KIND_READ       = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    typedef struct packed {
        logic             load;       // capture incoming word
        logic             pick;       // register the group candidates
        logic             apply;      // update slots and result
        logic             shift_up;
        logic             put_back;
        logic             remove;
        logic             take_read;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } dp_cmd_t;

endpackage

@@ rtl/core/bdq_dpath.sv @@
// Slot row and read select tree of the deque core.
// Depends on bdq_pkg; driven by bdq_ctrl commands.
module bdq_dpath import bdq_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dp_cmd_t                   cmd,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic signed [VALUE_W-1:0] m_read_value
);

    logic [VALUE_W-1:0] cells_reg [CAPACITY];
    logic [VALUE_W-1:0] cells_next [CAPACITY];
    logic [VALUE_W-1:0] grp_reg [NGROUP];
    logic [VALUE_W-1:0] grp_next [NGROUP];
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] rd_reg;
    logic [VALUE_W-1:0] rd_next;
    logic [GROUP_W-1:0] pos_lo;
    logic [IDX_W-1:0]   pos_hi;

    assign pos_lo = cmd.pos[GROUP_W-1:0];
    assign pos_hi = cmd.pos >> GROUP_W;

    // first level: one candidate per group
    always_comb begin
        int c;
        for (int g = 0; g < NGROUP; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                c = g * GROUP + j;
                if (c < CAPACITY && pos_lo == GROUP_W'(j)) begin
                    grp_next[g] = grp_next[g] | cells_reg[c];
                end
            end
        end
    end

    // second level picks the group; slots past the count always hold 0
    always_comb begin
        rd_next = '0;
        for (int g = 0; g < NGROUP; g++) begin
            if (pos_hi == IDX_W'(g)) begin
                rd_next = grp_reg[g];
            end
        end
        if (!cmd.take_read) begin
            rd_next = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cells_next[i] = cells_reg[i];
            if (cmd.apply) begin
                if (cmd.shift_up) begin
                    cells_next[i] = (i == 0) ? value_reg : cells_reg[(i == 0) ? 0 : i - 1];
                end else if (cmd.put_back && CNT_W'(i) == cmd.count) begin
                    cells_next[i] = value_reg;
                end else if (cmd.remove && IDX_W'(i) >= cmd.pos) begin
                    cells_next[i] = (i == CAPACITY - 1) ? '0
                                  : cells_reg[(i == CAPACITY - 1) ? i : i + 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CAPACITY; i++) begin
                cells_reg[i] <= '0;
            end
        end else begin
            cells_reg <= cells_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_value;
        end
        if (cmd.pick) begin
            grp_reg <= grp_next;
        end
        if (cmd.apply) begin
            rd_reg <= rd_next;
        end
    end

    assign m_read_value = rd_reg;

endmodule

@@ rtl/core/bdq_ctrl.sv @@
// Operation sequencer, fill count and result status of the deque core.
// Depends on bdq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bdq_ctrl import bdq_pkg::*; (
    input  logic                s_valid_i,
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [INDEX_W-1:0]  s_index,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [LENGTH_W-1:0] m_length,
    output dp_cmd_t             cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_APPLY
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [KIND_W-1:0]   kind_reg;
    status_t             op_status_reg;
    status_t             op_status_next;
    logic [IDX_W-1:0]    pos_reg;
    logic [IDX_W-1:0]    pos_next;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic                accept;
    logic                go;
    logic                ok;
    logic                full;
    logic                empty;
    logic                bad_idx;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid_i && s_ready;
    assign go      = (state_reg == S_APPLY) && (!m_valid_reg || m_ready);
    assign ok      = (op_status_reg == ST_OK);

    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign bad_idx = CMP_W'(s_index) >= CMP_W'(count_reg);

    always_comb begin
        op_status_next = ST_OK;
        pos_next       = '0;
        case (s_kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (full) op_status_next = ST_FULL;
            end
            KIND_POP_FRONT: begin
                if (empty) op_status_next = ST_EMPTY;
            end
            KIND_POP_BACK: begin
                if (empty) op_status_next = ST_EMPTY;
                pos_next = IDX_W'(count_reg - CNT_W'(1));
            end
            KIND_REMOVE, KIND_READ: begin
                if (empty) op_status_next = ST_EMPTY;
                else if (bad_idx) op_status_next = ST_BADIDX;
                pos_next = IDX_W'(s_index);
            end
            default: begin
                op_status_next = ST_OK;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (ok) begin
            case (kind_reg)
                KIND_PUSH_FRONT, KIND_PUSH_BACK: count_next = count_reg + CNT_W'(1);
                KIND_POP_FRONT, KIND_POP_BACK, KIND_REMOVE:
                    count_next = count_reg - CNT_W'(1);
                default: count_next = count_reg;
            endcase
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.pick      = (state_reg == S_PICK);
        cmd.apply     = go;
        cmd.shift_up  = ok && kind_reg == KIND_PUSH_FRONT;
        cmd.put_back  = ok && kind_reg == KIND_PUSH_BACK;
        cmd.remove    = ok && (kind_reg == KIND_POP_FRONT || kind_reg == KIND_POP_BACK ||
                               kind_reg == KIND_REMOVE);
        cmd.take_read = ok && (kind_reg == KIND_POP_FRONT || kind_reg == KIND_POP_BACK ||
                               kind_reg == KIND_REMOVE || kind_reg == KIND_READ);
        cmd.pos       = pos_reg;
        cmd.count     = count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
            kind_reg      <= '0;
            op_status_reg <= ST_OK;
            pos_reg       <= '0;
            status_reg    <= '0;
            length_reg    <= '0;
        end else begin
            // a new result replaces the one taken in the same cycle
            if (go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        kind_reg      <= s_kind;
                        op_status_reg <= op_status_next;
                        pos_reg       <= pos_next;
                        state_reg     <= S_PICK;
                    end
                end
                S_PICK: begin
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (go) begin
                        count_reg   <= count_next;
                        status_reg  <= op_status_reg;
                        length_reg  <= LENGTH_W'(count_next);
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;
    assign m_length = length_reg;

    `BDQ_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "fill count beyond capacity")
    `BDQ_ASSERT_NEXT(a_accept_pick, accept, state_reg == S_PICK, "accepted word not sequenced")
    `BDQ_ASSERT_NEXT(a_count_hold, !go, $stable(count_reg), "count moved outside apply")
    `BDQ_ASSERT(a_full_only_full, !(go && op_status_reg == ST_FULL) || full,
        "full status with free slots")

endmodule

@@ rtl/core/bounded_array_deque_unit.sv @@
// Top level of the bounded deque: sequencer plus slot datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_dpath.
//
//  channel   dir  handshake          word
//  s_        in   s_valid/s_ready    s_kind, s_value, s_index
//  m_        out  m_valid/m_ready    m_status, m_read_value, m_length
//
// Each word passes through capture, group select, then slot update and result.
// The slot row shifts in place in the update step; the read select is a two-level registered tree.
// A finished result sits in the output register while the next word is captured;
// the update cycle waits if that result has not yet been taken.
// Synchronous active-low reset empties the list and clears every slot.
module bounded_array_deque_unit import bdq_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [KIND_W-1:0]          s_kind,
    input  logic signed [VALUE_W-1:0]  s_value,
    input  logic [INDEX_W-1:0]         s_index,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [VALUE_W-1:0]  m_read_value,
    output logic [LENGTH_W-1:0]        m_length
);

    dp_cmd_t cmd;

    bdq_ctrl u_ctrl (
        .s_valid_i (s_valid),
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_kind    (s_kind),
        .s_index   (s_index),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_length  (m_length),
        .cmd       (cmd)
    );

    bdq_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_value      (s_value),
        .m_read_value (m_read_value)
    );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for bounded_array_deque_unit: directed, capacity,
// backpressure and random tests, checked against an in-bench deque predictor.
// Depends on bdq_pkg and the RTL of bounded_array_deque_unit.
module tb import bdq_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  read_value;
        logic [LENGTH_W-1:0]        length;
    } deque_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [KIND_W-1:0]          s_kind = '0;
    logic signed [VALUE_W-1:0]  s_value = '0;
    logic [INDEX_W-1:0]         s_index = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic signed [VALUE_W-1:0]  m_read_value;
    logic [LENGTH_W-1:0]        m_length;

    bounded_array_deque_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_value      (s_value),
        .s_index      (s_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_read_value (m_read_value),
        .m_length     (m_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predicted contents of the deque
    logic signed [VALUE_W-1:0] deque_slots [CAPACITY];
    int                        deque_len = 0;
    deque_result_t             pending_results [$];

    int unsigned failures = 0;
    int          burst_left = 0;
    bit          sender_steady = 1'b0;
    bit          hold_req = 1'b0;

    initial begin
        for (int i = 0; i < CAPACITY; i++) begin
            deque_slots[i] = '0;
        end
    end

    // close the gap at pos, clear the vacated slot
    function automatic void drop_slot(int pos);
        for (int i = pos; i + 1 < deque_len; i++) begin
            deque_slots[i] = deque_slots[i + 1];
        end
        deque_slots[deque_len - 1] = '0;
        deque_len--;
    endfunction

    function automatic deque_result_t deque_apply(logic [KIND_W-1:0] kind,
                                                  logic signed [VALUE_W-1:0] value,
                                                  logic [INDEX_W-1:0] index);
        deque_result_t r;
        r.status = ST_OK;
        r.read_value = '0;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (deque_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (kind == KIND_PUSH_FRONT) begin
                    for (int i = deque_len; i > 0; i--) begin
                        deque_slots[i] = deque_slots[i - 1];
                    end
                    deque_slots[0] = value;
                    deque_len++;
                end else begin
                    deque_slots[deque_len] = value;
                    deque_len++;
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (deque_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (kind == KIND_POP_FRONT) begin
                    r.read_value = deque_slots[0];
                    drop_slot(0);
                end else begin
                    r.read_value = deque_slots[deque_len - 1];
                    drop_slot(deque_len - 1);
                end
            end
            KIND_REMOVE, KIND_READ: begin
                if (deque_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(index) >= deque_len) begin
                    r.status = ST_BADIDX;
                end else begin
                    r.read_value = deque_slots[index];
                    if (kind == KIND_REMOVE) drop_slot(int'(index));
                end
            end
            default: ;
        endcase
        r.length = LENGTH_W'(deque_len);
        return r;
    endfunction

    // Offer one word; bursts of back-to-back words separated by random gaps.
    task automatic send_word(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] value,
                             logic [INDEX_W-1:0] index);
        int gap;
        if (burst_left == 0) begin
            gap = sender_steady ? 0 :
                  ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        s_index <= index;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(deque_apply(kind, value, index));
        burst_left--;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // mostly in-range indexes, now and then anything the field can hold
    task automatic random_op(int push_pct);
        int roll;
        logic [KIND_W-1:0] kind;
        logic [INDEX_W-1:0] index;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        end else if (roll >= 97) begin
            kind = $urandom_range(0, 1) ? KIND_UNUSED_A : KIND_UNUSED_B;
        end else begin
            kind = KIND_W'($urandom_range(KIND_POP_FRONT, KIND_READ));
        end
        if (deque_len > 0 && $urandom_range(0, 6) != 0) begin
            index = INDEX_W'($urandom_range(0, deque_len - 1));
        end else begin
            index = INDEX_W'($urandom());
        end
        send_word(kind, pick_value(), index);
    endtask

    task automatic test_empty_and_extremes();
        send_word(KIND_POP_FRONT, 32'sd5, 6'd0);
        send_word(KIND_POP_BACK, -32'sd5, 6'd63);
        send_word(KIND_REMOVE, 32'sd0, 6'd0);
        send_word(KIND_READ, 32'sd0, 6'd0);
        send_word(KIND_UNUSED_A, 32'sh7fff_ffff, 6'd63);
        send_word(KIND_UNUSED_B, 32'sh8000_0000, 6'd0);
        send_word(KIND_PUSH_FRONT, 32'sh8000_0000, 6'd63);
        send_word(KIND_PUSH_BACK, 32'sh7fff_ffff, 6'd0);
        send_word(KIND_PUSH_FRONT, 32'sd0, 6'd0);
        send_word(KIND_PUSH_BACK, -32'sd1, 6'd0);
        send_word(KIND_READ, 32'sd0, 6'd0);
        send_word(KIND_READ, 32'sd0, 6'd3);
        send_word(KIND_READ, 32'sd0, 6'd4);
        send_word(KIND_READ, 32'sd0, 6'd63);
        send_word(KIND_REMOVE, 32'sd0, 6'd63);
        send_word(KIND_UNUSED_A, 32'sd0, 6'd1);
        send_word(KIND_REMOVE, 32'sd0, 6'd1);
        send_word(KIND_POP_FRONT, 32'sd0, 6'd0);
        send_word(KIND_POP_BACK, 32'sd0, 6'd0);
        send_word(KIND_REMOVE, 32'sd0, 6'd0);
        send_word(KIND_POP_BACK, 32'sd0, 6'd0);
        wait_for_results();
    endtask

    task automatic test_full_capacity();
        while (deque_len < CAPACITY) begin
            send_word($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                      pick_value(), INDEX_W'($urandom()));
        end
        send_word(KIND_PUSH_FRONT, pick_value(), 6'd0);
        send_word(KIND_PUSH_BACK, pick_value(), 6'd63);
        send_word(KIND_READ, 32'sd0, 6'd63);
        send_word(KIND_READ, 32'sd0, 6'd32);
        send_word(KIND_REMOVE, 32'sd0, 6'd63);
        send_word(KIND_READ, 32'sd0, 6'd63);
        send_word(KIND_PUSH_FRONT, pick_value(), 6'd0);
        send_word(KIND_REMOVE, 32'sd0, 6'd31);
        send_word(KIND_PUSH_BACK, pick_value(), 6'd0);
        while (deque_len > 0) begin
            send_word(KIND_W'($urandom_range(KIND_POP_FRONT, KIND_REMOVE)),
                      pick_value(), INDEX_W'($urandom_range(0, deque_len - 1)));
        end
        wait_for_results();
    endtask

    // receiver holds off while the sender keeps the input full
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        sender_steady = 1'b1;
        repeat (40) random_op(60);
        sender_steady = 1'b0;
        wait_for_results();
    endtask

    // alternate growing and shrinking stretches so the length sweeps 0..CAPACITY
    task automatic test_random_traffic();
        int done_ops;
        int stretch;
        bit growing;
        done_ops = 0;
        growing = 1'b1;
        while (done_ops < 800) begin
            stretch = $urandom_range(60, 160);
            sender_steady = ($urandom_range(0, 4) == 0);
            repeat (stretch) random_op(growing ? 75 : 25);
            done_ops += stretch;
            growing = !growing;
            if ($urandom_range(0, 3) == 0) wait_for_results();
        end
        sender_steady = 1'b0;
        wait_for_results();
    endtask

    // receiver: random stall modes, plus one long hold on request
    initial begin
        int mode;
        int mode_left;
        int phase;
        mode = 0;
        mode_left = 0;
        phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                phase++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= (phase % 4 == 0);
                endcase
            end
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        deque_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: status %0d value %0d length %0d",
                       m_status, m_read_value, m_length);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    failures++;
                end
                if (m_read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value,
                           m_read_value);
                    failures++;
                end
                if (m_length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, m_length);
                    failures++;
                end
            end
        end
    end

    // watchdog: cycles without any handshake on either side
    always @(posedge aclk) begin
        int idle_cycles;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_extremes();
        test_full_capacity();
        test_output_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bdq_pkg.sv
rtl/core/bdq_dpath.sv
rtl/core/bdq_ctrl.sv
rtl/core/bounded_array_deque_unit.sv
test/tb.sv
